// File: sv/assert_macros.svh
// Assertion shorthands for the bitmap block allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of aclk while the block is out of reset.
`define BBA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every rising edge of aclk, reset included.
`define BBA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: sv/bba_pkg.sv
package bba_pkg;

    // Default sizing of the map and of one allocate request.
    localparam int DEF_MAP_BLOCKS  = 4096;
    localparam int DEF_MAX_REQUEST = 32;

    // Field widths of the request and result items.
    localparam int OP_W      = 2;
    localparam int IDX_W     = 12;
    localparam int REQ_CNT_W = 8;
    localparam int STATUS_W  = 2;

    // Stream widths; the data widths are padded to whole bytes.
    localparam int S_DATA_W = 24;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 16;
    localparam int M_USER_W = 3;

    localparam logic [7:0] BYTE_FULL = 8'hFF;
    localparam logic [7:0] MSB_BIT   = 8'h80;

    typedef enum logic [OP_W-1:0] {
        OP_MARK  = 2'd0,
        OP_FREE  = 2'd1,
        OP_ALLOC = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        RES_OK        = 2'd0,
        RES_RANGE     = 2'd1,
        RES_TOO_LARGE = 2'd2,
        RES_SHORT     = 2'd3
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // take the offered request
        logic clr_wr;     // write one zero byte of the clearing pass
        logic rmw_wr;     // write back the byte of a mark or free
        logic scan_load;  // load the byte just read into the work register
        logic scan_adv;   // move the scan to the next byte and read it
        logic grant;      // claim the lowest free bit and present a grant
        logic set_short;  // record a shortfall
        logic emit_fin;   // present the closing result without a block
    } bba_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        opcode_t in_op;
        logic    out_of_range;
        logic    too_large;
        logic    zero_req;
        logic    at_last;
        logic    ld_full;
        logic    grant_done;
        logic    grant_full;
        logic    out_free;
    } bba_stat_t;

endpackage

// File: sv/bba_ctrl.sv
module bba_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  bba_pkg::bba_stat_t  stat,
    output bba_pkg::bba_cmd_t   cmd
);
    import bba_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_RMW   = 6'b000100,
        S_SCAN  = 6'b001000,
        S_GRANT = 6'b010000,
        S_FIN   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Sequencing of each request.
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_tready   = (state_reg == S_IDLE);
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (stat.at_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (stat.in_op inside {OP_MARK, OP_FREE}) begin
                        state_next = stat.out_of_range ? S_FIN : S_RMW;
                    end else if (stat.in_op == OP_ALLOC) begin
                        state_next = (stat.too_large || stat.zero_req) ? S_FIN : S_SCAN;
                    end
                end
            end
            S_RMW: begin
                cmd.rmw_wr = 1'b1;
                state_next = S_FIN;
            end
            S_SCAN: begin
                cmd.scan_load = 1'b1;
                if (!stat.ld_full) begin
                    state_next = S_GRANT;
                end else if (stat.at_last) begin
                    cmd.set_short = 1'b1;
                    state_next    = S_FIN;
                end else begin
                    cmd.scan_adv = 1'b1;
                end
            end
            S_GRANT: begin
                if (stat.out_free) begin
                    cmd.grant = 1'b1;
                    if (stat.grant_done) begin
                        state_next = S_IDLE;
                    end else if (stat.grant_full) begin
                        if (stat.at_last) begin
                            cmd.set_short = 1'b1;
                            state_next    = S_FIN;
                        end else begin
                            cmd.scan_adv = 1'b1;
                            state_next   = S_SCAN;
                        end
                    end
                end
            end
            S_FIN: begin
                if (stat.out_free) begin
                    cmd.emit_fin = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/bba_dp.sv
module bba_dp #(
    parameter int MAP_BLOCKS  = bba_pkg::DEF_MAP_BLOCKS,
    parameter int MAX_REQUEST = bba_pkg::DEF_MAX_REQUEST
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [bba_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic [bba_pkg::S_USER_W-1:0]  s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bba_pkg::M_DATA_W-1:0]  m_tdata,
    output logic [bba_pkg::M_USER_W-1:0]  m_tuser,
    output logic                          m_tlast,
    input  bba_pkg::bba_cmd_t             cmd,
    output bba_pkg::bba_stat_t            stat
);
    import bba_pkg::*;

    localparam int MAP_BYTES = (MAP_BLOCKS + 7) / 8;
    localparam int ADDR_W    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int REQ_W     = $clog2(MAX_REQUEST + 1);
    localparam int TAIL      = MAP_BLOCKS % 8;
    localparam logic [7:0] PAD_MASK = (TAIL == 0) ? 8'h00 : 8'(BYTE_FULL >> TAIL);
    localparam logic [ADDR_W-1:0] LAST_BYTE = ADDR_W'(MAP_BYTES - 1);

    // Usage map, one byte per eight blocks, first block in the top bit.
    logic [7:0] mem [MAP_BYTES];

    opcode_t              in_op;
    logic [IDX_W-1:0]     in_idx;
    logic [REQ_CNT_W-1:0] in_cnt;

    opcode_t              op_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [REQ_W-1:0]     want_reg;
    logic [REQ_W-1:0]     got_reg;
    logic [ADDR_W-1:0]    byte_addr_reg;
    logic [7:0]           work_reg;
    logic [7:0]           rdata_reg;
    status_t              status_reg;

    logic                 out_valid_reg;
    logic [IDX_W-1:0]     out_idx_reg;
    logic                 out_gv_reg;
    status_t              out_status_reg;
    logic                 out_last_reg;

    logic [ADDR_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [7:0]           wr_data;
    logic [7:0]           rmw_bit;
    logic [2:0]           pick;
    logic [7:0]           work_next;
    logic [REQ_W:0]       got_inc;
    logic [7:0]           ld_byte;
    logic                 at_last;
    logic                 grant_done;
    logic                 out_free;

    // Request fields.
    assign in_op  = opcode_t'(s_tuser[OP_W-1:0]);
    assign in_idx = s_tdata[IDX_W-1:0];
    assign in_cnt = s_tdata[IDX_W +: REQ_CNT_W];

    assign at_last    = (byte_addr_reg == LAST_BYTE);
    assign ld_byte    = rdata_reg | (at_last ? PAD_MASK : 8'h00);
    assign got_inc    = {1'b0, got_reg} + 1'b1;
    assign grant_done = (got_inc == {1'b0, want_reg});
    assign out_free   = !out_valid_reg || m_tready;
    assign rmw_bit    = MSB_BIT >> idx_reg[2:0];

    // Lowest free block of the byte under scan.
    always_comb begin
        logic found;
        found = 1'b0;
        pick  = '0;
        for (int p = 0; p < 8; p++) begin
            if (!found && !work_reg[7 - p]) begin
                pick  = 3'(p);
                found = 1'b1;
            end
        end
    end
    assign work_next = work_reg | (MSB_BIT >> pick);

    // Status towards the controller.
    always_comb begin
        stat              = '0;
        stat.in_op        = in_op;
        stat.out_of_range = (32'(in_idx) >= 32'(MAP_BLOCKS));
        stat.too_large    = (32'(in_cnt) > 32'(MAX_REQUEST));
        stat.zero_req     = (in_cnt == '0);
        stat.at_last      = at_last;
        stat.ld_full      = (ld_byte == BYTE_FULL);
        stat.grant_done   = grant_done;
        stat.grant_full   = (work_next == BYTE_FULL);
        stat.out_free     = out_free;
    end

    // Map read address: the new request's byte, the next scan byte or the current one.
    always_comb begin
        if (cmd.accept) begin
            rd_addr = (in_op == OP_ALLOC) ? '0 : ADDR_W'(in_idx >> 3);
        end else if (cmd.scan_adv) begin
            rd_addr = byte_addr_reg + 1'b1;
        end else begin
            rd_addr = byte_addr_reg;
        end
    end

    // Map write port.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = byte_addr_reg;
        wr_data = 8'h00;
        if (cmd.clr_wr) begin
            wr_en = 1'b1;
        end else if (cmd.rmw_wr) begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(idx_reg >> 3);
            wr_data = (op_reg == OP_MARK) ? (rdata_reg | rmw_bit) : (rdata_reg & ~rmw_bit);
        end else if (cmd.grant) begin
            wr_en   = grant_done || (work_next == BYTE_FULL);
            wr_data = work_next;
        end
    end

    // Map memory with registered read.
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[rd_addr];
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Byte pointer, used by the clearing pass and the scan.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_addr_reg <= '0;
        end else if (cmd.accept) begin
            byte_addr_reg <= '0;
        end else if (cmd.clr_wr || cmd.scan_adv) begin
            byte_addr_reg <= byte_addr_reg + 1'b1;
        end
    end

    // Request registers and scan state.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg   <= in_op;
            idx_reg  <= in_idx;
            want_reg <= REQ_W'(in_cnt);
            got_reg  <= '0;
            if (in_op == OP_ALLOC) begin
                status_reg <= stat.too_large ? RES_TOO_LARGE : RES_OK;
            end else begin
                status_reg <= stat.out_of_range ? RES_RANGE : RES_OK;
            end
        end else if (cmd.set_short) begin
            status_reg <= RES_SHORT;
        end
        if (cmd.grant) begin
            got_reg  <= got_inc[REQ_W-1:0];
            work_reg <= work_next;
        end else if (cmd.scan_load) begin
            work_reg <= ld_byte;
        end
    end

    // Output register towards the result stream.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.grant || cmd.emit_fin) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.grant) begin
            out_idx_reg    <= IDX_W'({byte_addr_reg, pick});
            out_gv_reg     <= 1'b1;
            out_status_reg <= RES_OK;
            out_last_reg   <= grant_done;
        end else if (cmd.emit_fin) begin
            out_idx_reg    <= '0;
            out_gv_reg     <= 1'b0;
            out_status_reg <= status_reg;
            out_last_reg   <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - IDX_W){1'b0}}, out_idx_reg};
    assign m_tuser  = {out_status_reg, out_gv_reg};
    assign m_tlast  = out_last_reg;

endmodule

// File: sv/bitmap_block_allocator_core.sv
// First-fit block allocator over a used/free bitmap of MAP_BLOCKS blocks, kept in an on-chip
// memory of (MAP_BLOCKS+7)/8 bytes. After reset the block runs a clearing pass of one map byte
// per cycle with s_tready low. One request is worked on at a time; the next is taken in the
// cycle after its last result has entered the output register, so a waiting result does not
// hold the input back. Mark and free read, modify and write one map byte and then give their
// result; a rejected request or a zero-count allocate goes straight to its closing result,
// and an unused opcode is taken without any result. An allocate reads the map a byte at a
// time from the first (the map memory delivers one byte a cycle), passes over full bytes and
// grants the free blocks of a byte one by one, the write-back of a byte overlapping the grant
// that fills it; a shortfall adds one closing result. Backpressure on the result stream
// stalls the grant sequence without loss.
`include "assert_macros.svh"

module bitmap_block_allocator_core #(
    parameter int MAP_BLOCKS  = bba_pkg::DEF_MAP_BLOCKS,
    parameter int MAX_REQUEST = bba_pkg::DEF_MAX_REQUEST
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [11:0] block_index, [19:12] request_count, [23:20] zero
    input  logic [bba_pkg::S_DATA_W-1:0]  s_tdata,
    // [1:0] opcode
    input  logic [bba_pkg::S_USER_W-1:0]  s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [11:0] granted_index, [15:12] zero
    output logic [bba_pkg::M_DATA_W-1:0]  m_tdata,
    // [0] granted_valid, [2:1] status
    output logic [bba_pkg::M_USER_W-1:0]  m_tuser,
    output logic                          m_tlast
);
    import bba_pkg::*;

    bba_cmd_t  cmd;
    bba_stat_t stat;

    // Request sequencer.
    bba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Map memory, scan logic and output register.
    bba_dp #(
        .MAP_BLOCKS  (MAP_BLOCKS),
        .MAX_REQUEST (MAX_REQUEST)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .stat     (stat)
    );

    // A result is only loaded when the output register is empty or draining.
    `BBA_ASSERT(a_no_overwrite, (cmd.grant || cmd.emit_fin) |-> (!m_tvalid || m_tready), "result loaded over a waiting result")
    // A grant shows up as a valid block with an ok status.
    `BBA_ASSERT(a_grant_shown, cmd.grant |=> m_tvalid && m_tuser[0] && (m_tuser[2:1] == RES_OK), "grant not presented")
    // A closing result carries no block and ends the request.
    `BBA_ASSERT(a_fin_shown, cmd.emit_fin |=> m_tvalid && m_tlast && !m_tuser[0], "closing result malformed")
    // Coming out of reset nothing is offered and no request is taken.
    `BBA_ASSERT_ALWAYS(a_reset_quiet, !aresetn |=> !m_tvalid && !s_tready, "activity straight after reset")

endmodule
